// ===== rtl/core/sha_pkg.sv =====
package sha_pkg;

  localparam int unsigned NumRounds = 64;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAD,
    BK_ROUND,
    BK_ADD,
    BK_EMIT
  } bk_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    begin
      unique case (idx)
        6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
        6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
        6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
        6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
        6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
        6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
        6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
        6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
        6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
        6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
        6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
        6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
        6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
        6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
        6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
        6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
        6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
        6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
        6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
        6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
        6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
        6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    begin
      unique case (idx)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha_front.sv =====
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  output logic              q_valid,
  output sha_pkg::item_t    q_item,
  input  logic              q_take
);

  sha_pkg::item_t  mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            do_push;

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= '{kind: in_kind, data_byte: in_data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, q_take};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !do_push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("count out of range");
`endif

endmodule

// ===== rtl/core/sha_back.sv =====
module sha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sha_pkg::item_t    q_item,
  output logic              q_take,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  sha_pkg::bk_state_t state_r, state_nxt;

  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;
  logic        fin_r;    // Current compression belongs to a finish.
  logic        second_r; // The length-only block is being built or compressed.
  logic        two_r;    // The finish needs a second, length-only block.
  logic        mark_r;   // The 0x80 pad byte is still to be placed.
  logic [63:0] total_r;
  logic [2:0]  oidx_r;

  logic [31:0] wt, s0, s1, wn, t1, t2, e, a;
  logic [7:0]  pad_byte, byte_in;
  logic        byte_shift;

  assign empty           = (state_r != sha_pkg::BK_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  always_comb begin
    wt = w_r[0];
    s0 = sha_pkg::ror(w_r[1], 7) ^ sha_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha_pkg::ror(w_r[14], 17) ^ sha_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = s1 + w_r[9] + s0 + w_r[0];
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + sha_pkg::round_k(rnd_r) + wt;
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Padding bytes in message order: 0x80 first, then zeros, and the big-endian
  // bit length in the last eight bytes of the block that carries it.
  always_comb begin
    if (mark_r) begin
      pad_byte = 8'h80;
    end else if (fill_r >= 6'd56 && (second_r || !two_r)) begin
      pad_byte = total_r[{~fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
    byte_shift = (state_r == sha_pkg::BK_PAD) ||
                 (state_r == sha_pkg::BK_IDLE && q_valid && !q_item.kind);
    byte_in    = (state_r == sha_pkg::BK_PAD) ? pad_byte : q_item.data_byte;
  end

  always_comb begin
    state_nxt = state_r;
    q_take    = 1'b0;
    unique case (state_r)
      sha_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (q_item.kind) state_nxt = sha_pkg::BK_PAD;
          else if (fill_r == 6'd63) state_nxt = sha_pkg::BK_ROUND;
        end
      end
      sha_pkg::BK_PAD:   if (fill_r == 6'd63) state_nxt = sha_pkg::BK_ROUND;
      sha_pkg::BK_ROUND: begin
        if (rnd_r == 6'(sha_pkg::NumRounds - 1)) state_nxt = sha_pkg::BK_ADD;
      end
      sha_pkg::BK_ADD: begin
        if (!fin_r) state_nxt = sha_pkg::BK_IDLE;
        else if (two_r && !second_r) state_nxt = sha_pkg::BK_PAD;
        else state_nxt = sha_pkg::BK_EMIT;
      end
      sha_pkg::BK_EMIT:  if (pop && oidx_r == 3'd7) state_nxt = sha_pkg::BK_IDLE;
      default:           state_nxt = sha_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sha_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  // The schedule window doubles as the block buffer: bytes shift in at the low
  // byte of w_r[15], so after 64 bytes the first message word sits in w_r[0].
  always_ff @(posedge clk) begin
    if (byte_shift) begin
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], byte_in};
    end else if (state_r == sha_pkg::BK_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::BK_ROUND) begin
      for (int i = 1; i < 8; i++) v_r[i] <= v_r[i-1];
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
    if (state_r == sha_pkg::BK_IDLE && q_valid && q_item.kind) begin
      total_r <= bits_r + {55'd0, fill_r, 3'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_h(3'(i));
      fill_r   <= '0;
      bits_r   <= '0;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      two_r    <= 1'b0;
      mark_r   <= 1'b0;
      oidx_r   <= '0;
    end else begin
      unique case (state_r)
        sha_pkg::BK_IDLE: begin
          rnd_r <= '0;
          if (q_valid) begin
            if (q_item.kind) begin
              fin_r    <= 1'b1;
              second_r <= 1'b0;
              mark_r   <= 1'b1;
              two_r    <= (fill_r >= 6'd56);
            end else begin
              fin_r  <= 1'b0;
              fill_r <= fill_r + 6'd1;
              if (fill_r == 6'd63) bits_r <= bits_r + 64'd512;
            end
          end
        end
        sha_pkg::BK_PAD: begin
          rnd_r  <= '0;
          fill_r <= fill_r + 6'd1;
          mark_r <= 1'b0;
        end
        sha_pkg::BK_ROUND: rnd_r <= rnd_r + 6'd1;
        sha_pkg::BK_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (fin_r && two_r && !second_r) second_r <= 1'b1;
        end
        sha_pkg::BK_EMIT: begin
          if (pop) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_h(3'(i));
              fill_r   <= '0;
              bits_r   <= '0;
              fin_r    <= 1'b0;
              second_r <= 1'b0;
              two_r    <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> state_r == sha_pkg::BK_IDLE) else $error("take outside idle");
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::BK_ROUND && rnd_r == 6'd63) |=> state_r == sha_pkg::BK_ADD)
    else $error("round count slip");
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == sha_pkg::BK_EMIT) |-> oidx_r == 3'd0) else $error("emit index");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::BK_EMIT && pop && oidx_r == 3'd7) |=> fill_r == 6'd0)
    else $error("no restart after digest");
`endif

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// Channel | Ports                                          | Transfer when
// input   | in_kind, in_data_byte, push, full              | push && !full
// result  | out_digest_word, out_word_index, out_last_word | pop && !empty
//
// A data byte is taken from the queue while idle; the 64th byte of a block starts
// the round loop (one round per cycle) and the chaining add.
// A finish with f bytes held pads the block (one byte per cycle) and compresses it,
// then a second, length-only block when f is 56 or above, then eight result transfers.
// Reset (rst_n low at a clock edge) loads the initial hash and clears counts.
// A two-entry queue holds input while the back end compresses or waits on pop.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic           q_valid, q_take;
  sha_pkg::item_t q_item;

  sha_front u_front (
    .clk, .rst_n, .push, .full, .in_kind, .in_data_byte,
    .q_valid, .q_item, .q_take
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_take, .empty, .pop,
    .out_digest_word, .out_word_index, .out_last_word
  );

endmodule

// ===== bench/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_FINISH = 1'b1
  } item_kind_t;

  typedef struct {
    logic        kind;
    logic [7:0]  data_byte;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned MaxGap = 18;
  localparam int unsigned LongHold = 600;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_kind;
  logic [7:0]  in_data_byte;
  logic        empty;
  logic        pop;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .empty           (empty),
    .pop             (pop),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hash state mirrored by the predictor.
  logic [31:0] hash_chain [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [63:0] bit_total;

  byte_item_t   pending_items[$];
  digest_word_t expected_digest[$];

  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          hold_request;
  logic        full_at_edge;
  logic        popped_at_edge;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] round_constant(input int unsigned i);
    logic [31:0] k_tab [64];
    k_tab = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k_tab[i];
  endfunction

  task automatic restart_hash();
    hash_chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    block_fill = '0;
    bit_total  = '0;
  endtask

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, maj;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = hash_chain;
    for (int i = 0; i < 64; i++) begin
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + round_constant(i) + w[i];
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
  endtask

  task automatic predict_hash_step(input byte_item_t it);
    logic [63:0]  total;
    digest_word_t dw;
    if (it.kind == KIND_DATA) begin
      msg_block[block_fill] = it.data_byte;
      if (block_fill == 6'd63) begin
        compress_msg_block();
        bit_total += 64'd512;
      end
      block_fill = block_fill + 6'd1;
    end else begin
      total = bit_total + 64'(block_fill) * 8;
      msg_block[block_fill] = 8'h80;
      for (int k = int'(block_fill) + 1; k < 64; k++) msg_block[k] = 8'h00;
      if (block_fill >= 6'd56) begin
        compress_msg_block();
        for (int k = 0; k < 56; k++) msg_block[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) msg_block[63-k] = total[8*k +: 8];
      compress_msg_block();
      for (int k = 0; k < 8; k++) begin
        dw.word  = hash_chain[k];
        dw.index = 3'(k);
        dw.last  = (k == 7);
        expected_digest.push_back(dw);
      end
      restart_hash();
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    byte_item_t it;
    it.kind = KIND_DATA;
    it.data_byte = b;
    pending_items.push_back(it);
  endtask

  task automatic add_finish(input logic [7:0] junk);
    byte_item_t it;
    it.kind = KIND_FINISH;
    it.data_byte = junk;
    pending_items.push_back(it);
  endtask

  task automatic add_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)));
    add_finish(8'($urandom_range(0, 255)));
  endtask

  // Driver: one item per transfer, random gap before each one.
  int unsigned send_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      send_gap <= $urandom_range(0, MaxGap);
    end else if (push && full_at_edge) begin
      // Offer stays up until the transfer happens.
    end else if (push && !full_at_edge) begin
      if (send_gap == 0 && pending_items.size() != 0) begin
        in_kind      <= pending_items[0].kind;
        in_data_byte <= pending_items[0].data_byte;
        void'(pending_items.pop_front());
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
      end else begin
        push <= 1'b0;
      end
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
    end else if (pending_items.size() != 0) begin
      push         <= 1'b1;
      in_kind      <= pending_items[0].kind;
      in_data_byte <= pending_items[0].data_byte;
      void'(pending_items.pop_front());
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
    end
  end

  // Transfer seen at the rising edge; the driver reads it at the next falling edge.
  always @(posedge clk) begin
    full_at_edge <= full;
    if (rst_n && push && !full) begin
      byte_item_t it;
      it.kind = in_kind;
      it.data_byte = in_data_byte;
      predict_hash_step(it);
    end
  end

  // Receiver: pop with random stalls, plus a long hold-off when requested.
  int unsigned pop_wait;
  int unsigned hold_count;
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      pop_wait <= $urandom_range(0, MaxGap);
      hold_count <= 0;
    end else if (hold_request && hold_count < LongHold) begin
      pop <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (pop && !popped_at_edge) begin
      // Keep offering until a word actually moves.
    end else if (pop_wait != 0) begin
      pop <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else begin
      pop <= 1'b1;
      pop_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
    end
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    popped_at_edge <= rst_n && pop && !empty;
    if (rst_n && pop && !empty) begin
      if (expected_digest.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected digest word %h index %0d", out_digest_word, out_word_index);
      end else begin
        exp_w = expected_digest.pop_front();
        if (out_digest_word !== exp_w.word || out_word_index !== exp_w.index ||
            out_last_word !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                     exp_w.word, exp_w.index, exp_w.last,
                     out_digest_word, out_word_index, out_last_word);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_kind = KIND_DATA;
    in_data_byte = 8'h00;
    full_at_edge = 1'b0;
    popped_at_edge = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    hold_request = 1'b0;
    restart_hash();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;

    // Directed: empty message, "abc", two bytes, boundary lengths 55/56/63/64/65 bytes.
    add_finish(8'hff);
    add_byte(8'h61); add_byte(8'h62); add_byte(8'h63); add_finish(8'h00);
    add_byte(8'h00); add_byte(8'hff); add_finish(8'hff);
    add_message(55);
    add_message(56);
    add_message(63);
    add_message(64);
    add_message(65);
    add_message(0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Back pressure: stall the receiver long while several messages queue up.
    hold_request = 1'b1;
    for (int m = 0; m < 4; m++) add_message($urandom_range(0, 3));

    // Random messages, mostly short, a few spanning several blocks.
    len = 0;
    while (len < 180) begin
      int unsigned n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 140) : $urandom_range(0, 20);
      add_message(n);
      len += n + 1;
    end

    wait (pending_items.size() == 0 && !push);
    wait (expected_digest.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_digest.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
